@@ hdl/sscm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sscm_pkg
// Shared types, constants and helper functions of the span subpixel
// coverage mask builder.
// ----------------------------------------------------------------------------
package sscm_pkg;

    localparam int LINE_PIXELS = 1024;
    localparam int PIX_W       = $clog2(LINE_PIXELS);
    localparam int EDGE_W      = 13;
    localparam int FRAC_W      = 3;
    localparam int PXF_W       = 10;
    localparam int NUM_SUBS    = 4;
    localparam int SUB_W       = 2;
    localparam int OP_W        = 2;
    localparam int COV_W       = 8;
    localparam int S_DATA_W    = 64;

    typedef logic [PIX_W-1:0]  pix_t;
    typedef logic [EDGE_W-1:0] edge_t;
    typedef logic [OP_W-1:0]   op_t;
    typedef logic [COV_W-1:0]  cov_t;
    typedef logic [3:0]        nib_t;

    localparam op_t OP_LOAD = 2'd0;
    localparam op_t OP_SPAN = 2'd1;
    localparam op_t OP_READ = 2'd2;

    localparam nib_t       NIB_EVEN  = 4'ha;
    localparam nib_t       NIB_ODD   = 4'h5;
    localparam nib_t       NIB_FULL  = 4'hf;
    localparam logic [7:0] HIGH_FILL = 8'hf0;
    localparam cov_t       COV_FULL  = 8'hff;

    // clamp a pixel index to the last pixel of the line
    function automatic pix_t clamp_px(input logic [PXF_W-1:0] v);
        pix_t r;
        if (int'(v) > LINE_PIXELS - 1)
            r = PIX_W'(LINE_PIXELS - 1);
        else
            r = PIX_W'(v);
        return r;
    endfunction

    function automatic nib_t sub_nib(input logic [SUB_W-1:0] sub);
        return sub[0] ? NIB_ODD : NIB_EVEN;
    endfunction

    // subscanlines 0 and 1 sit in the high nibble
    function automatic cov_t place_nib(input logic [SUB_W-1:0] sub, input nib_t nib);
        return sub[SUB_W-1] ? {4'h0, nib} : {nib, 4'h0};
    endfunction

    function automatic logic [2:0] frac_shift(input logic [FRAC_W-1:0] frac);
        logic [3:0] t;
        t = {1'b0, frac} + 4'd1;
        return t[3:1];
    endfunction

    function automatic nib_t left_nib(input logic [FRAC_W-1:0] frac, input nib_t m);
        return (NIB_FULL >> frac_shift(frac)) & m;
    endfunction

    function automatic nib_t right_nib(input logic [FRAC_W-1:0] frac, input nib_t m);
        logic [7:0] t;
        t = HIGH_FILL >> frac_shift(frac);
        return t[3:0] & m;
    endfunction

endpackage

@@ hdl/sscm_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sscm_ram
// Generic simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module sscm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ hdl/span_subpixel_coverage_mask.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// span_subpixel_coverage_mask
// Builds per-pixel subpixel coverage bytes of one span in a line buffer and
// reads them back.
//
// channel  dir  handshake          payload
// s_*      in   s_tvalid/s_tready  s_tuser opcode, s_tdata item fields
// m_*      out  m_tvalid/m_tready  m_tdata coverage byte
//
// load: stores one subscanline's edges. read: the line buffer is read on
// accept, then registered for output in the read state. span: setup, one
//   subscanline per cycle, then a walk from the lowest to the highest pixel
//   touched with one read-modify-write per cycle, then write-back.
// s_tready is high only while the sequencer is idle; a held result does not
// block loads or spans. reset clears the subscanline edges and marks them
// invalid; the line buffer is not cleared.
// ----------------------------------------------------------------------------
module span_subpixel_coverage_mask (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // sub_index, minor_edge, major_edge, sub_invalid, left_end, right_end,
    // flip, pixel_x, zero fill
    input  logic [sscm_pkg::S_DATA_W-1:0]  s_tdata,
    // opcode
    input  logic [sscm_pkg::OP_W-1:0]      s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // coverage_byte
    output logic [sscm_pkg::COV_W-1:0]     m_tdata
);

    import sscm_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SETUP = 3'd1;
    localparam logic [2:0] ST_WALK  = 3'd2;
    localparam logic [2:0] ST_FLUSH = 3'd3;
    localparam logic [2:0] ST_RD    = 3'd4;

    // item fields
    logic [SUB_W-1:0] in_sub;
    edge_t            in_minor;
    edge_t            in_major;
    logic             in_invalid;
    logic [PXF_W-1:0] in_left;
    logic [PXF_W-1:0] in_right;
    logic             in_flip;
    logic [PXF_W-1:0] in_pixel;
    logic             accept;

    assign in_sub     = s_tdata[1:0];
    assign in_minor   = s_tdata[14:2];
    assign in_major   = s_tdata[27:15];
    assign in_invalid = s_tdata[28];
    assign in_left    = s_tdata[38:29];
    assign in_right   = s_tdata[48:39];
    assign in_flip    = s_tdata[49];
    assign in_pixel   = s_tdata[59:50];
    assign accept     = s_tvalid && s_tready;

    // control state
    logic [2:0]       state_reg, state_next;
    logic [SUB_W-1:0] sub_cnt_reg, sub_cnt_next;
    logic             wr_pend_reg;
    logic             out_valid_reg, out_valid_next;
    edge_t            sub_minor_reg [NUM_SUBS];
    edge_t            sub_major_reg [NUM_SUBS];
    logic [NUM_SUBS-1:0] sub_inv_reg;

    // span payload
    pix_t             start_reg, end_reg, lo_reg, hi_reg, addr_reg, wr_addr_reg;
    logic             flip_reg, oob_reg;
    pix_t             li_reg [NUM_SUBS];
    pix_t             ri_reg [NUM_SUBS];
    nib_t             lnib_reg [NUM_SUBS];
    nib_t             rnib_reg [NUM_SUBS];
    cov_t             out_data_reg;

    // ram
    logic             ram_rd_en;
    pix_t             ram_rd_addr;
    cov_t             ram_rd_data;
    cov_t             new_byte;

    // span ends of the incoming item
    pix_t             span_start, span_end;
    assign span_start = in_flip ? clamp_px(in_right) : clamp_px(in_left);
    assign span_end   = in_flip ? clamp_px(in_left) : clamp_px(in_right);

    // setup unit, one subscanline per cycle
    edge_t            set_lx, set_rx;
    pix_t             set_li, set_ri, set_lo, set_hi;
    nib_t             set_m;

    always_comb
    begin
        set_lx = flip_reg ? sub_major_reg[sub_cnt_reg] : sub_minor_reg[sub_cnt_reg];
        set_rx = flip_reg ? sub_minor_reg[sub_cnt_reg] : sub_major_reg[sub_cnt_reg];
        set_li = clamp_px(set_lx[EDGE_W-1:FRAC_W]);
        set_ri = clamp_px(set_rx[EDGE_W-1:FRAC_W]);
        set_m  = sub_nib(sub_cnt_reg);
        set_lo = lo_reg;
        set_hi = hi_reg;
        if (!sub_inv_reg[sub_cnt_reg])
        begin
            if (set_li < set_lo)
                set_lo = set_li;
            if (set_ri < set_lo)
                set_lo = set_ri;
            if (set_li > set_hi)
                set_hi = set_li;
            if (set_ri > set_hi)
                set_hi = set_ri;
        end
    end

    // pixel unit, applied to the pixel whose old byte comes back from the ram
    always_comb
    begin
        logic in_span;
        logic clr;
        cov_t base;
        cov_t lane;
        in_span  = (wr_addr_reg >= start_reg) && (wr_addr_reg <= end_reg);
        base     = in_span ? COV_FULL : ram_rd_data;
        new_byte = '0;
        for (int i = 0; i < NUM_SUBS; i++)
        begin
            clr  = 1'b0;
            lane = base & place_nib(SUB_W'(i), sub_nib(SUB_W'(i)));
            if (sub_inv_reg[i])
            begin
                if (in_span)
                    lane = '0;
            end
            else
            begin
                clr = ((wr_addr_reg >= start_reg) && (wr_addr_reg <= li_reg[i])) ||
                      ((wr_addr_reg >= ri_reg[i]) && (wr_addr_reg <= end_reg));
                if (clr)
                    lane = '0;
                if (ri_reg[i] > li_reg[i])
                begin
                    if (wr_addr_reg == li_reg[i])
                        lane = lane | place_nib(SUB_W'(i), lnib_reg[i]);
                    if (wr_addr_reg == ri_reg[i])
                        lane = lane | place_nib(SUB_W'(i), rnib_reg[i]);
                end
                else if ((ri_reg[i] == li_reg[i]) && (wr_addr_reg == li_reg[i]))
                begin
                    lane = lane | place_nib(SUB_W'(i), lnib_reg[i] & rnib_reg[i]);
                end
            end
            new_byte = new_byte | lane;
        end
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        sub_cnt_next   = sub_cnt_reg;
        out_valid_next = out_valid_reg;
        if (m_tready)
            out_valid_next = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (s_tuser == OP_SPAN) && (span_end >= span_start))
                begin
                    state_next   = ST_SETUP;
                    sub_cnt_next = '0;
                end
                else if (accept && (s_tuser == OP_READ))
                begin
                    state_next = ST_RD;
                end
            end
            ST_SETUP:
            begin
                sub_cnt_next = sub_cnt_reg + 1'b1;
                if (sub_cnt_reg == SUB_W'(NUM_SUBS - 1))
                    state_next = ST_WALK;
            end
            ST_WALK:
            begin
                if (addr_reg == hi_reg)
                    state_next = ST_FLUSH;
            end
            ST_FLUSH:
            begin
                state_next = ST_IDLE;
            end
            ST_RD:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            sub_cnt_reg   <= '0;
            wr_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            sub_inv_reg   <= '1;
            for (int i = 0; i < NUM_SUBS; i++)
            begin
                sub_minor_reg[i] <= '0;
                sub_major_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            sub_cnt_reg   <= sub_cnt_next;
            wr_pend_reg   <= (state_reg == ST_WALK);
            out_valid_reg <= out_valid_next;
            if (accept && (s_tuser == OP_LOAD))
            begin
                sub_minor_reg[in_sub] <= in_minor;
                sub_major_reg[in_sub] <= in_major;
                sub_inv_reg[in_sub]   <= in_invalid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        wr_addr_reg <= addr_reg;
        if (accept && (s_tuser == OP_SPAN))
        begin
            start_reg <= span_start;
            end_reg   <= span_end;
            lo_reg    <= span_start;
            hi_reg    <= span_end;
            flip_reg  <= in_flip;
        end
        if (accept && (s_tuser == OP_READ))
        begin
            oob_reg <= (int'(in_pixel) >= LINE_PIXELS);
        end
        if (state_reg == ST_SETUP)
        begin
            li_reg[sub_cnt_reg]   <= set_li;
            ri_reg[sub_cnt_reg]   <= set_ri;
            lnib_reg[sub_cnt_reg] <= left_nib(set_lx[FRAC_W-1:0], set_m);
            rnib_reg[sub_cnt_reg] <= right_nib(set_rx[FRAC_W-1:0], set_m);
            lo_reg                <= set_lo;
            hi_reg                <= set_hi;
            addr_reg              <= set_lo;
        end
        else if (state_reg == ST_WALK)
        begin
            addr_reg <= addr_reg + 1'b1;
        end
        if ((state_reg == ST_RD) && (!out_valid_reg || m_tready))
        begin
            out_data_reg <= oob_reg ? '0 : ram_rd_data;
        end
    end

    assign ram_rd_en   = (state_reg == ST_WALK) || (accept && (s_tuser == OP_READ));
    assign ram_rd_addr = (state_reg == ST_WALK) ? addr_reg : clamp_px(in_pixel);

    sscm_ram #(
        .WIDTH (COV_W),
        .DEPTH (LINE_PIXELS)
    ) u_line_ram (
        .clk     (clk),
        .wr_en   (wr_pend_reg),
        .wr_addr (wr_addr_reg),
        .wr_data (new_byte),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

`ifndef SYNTHESIS
    a_wr_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
        wr_pend_reg |-> (state_reg == ST_WALK) || (state_reg == ST_FLUSH))
        else $error("line buffer write outside span walk");

    a_walk_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK) |-> (addr_reg >= lo_reg) && (addr_reg <= hi_reg))
        else $error("walk address outside touched range");

    a_wr_addr: assert property (@(posedge clk) disable iff (!rst_n)
        wr_pend_reg |-> (wr_addr_reg == $past(ram_rd_addr)) && $past(ram_rd_en))
        else $error("write-back address does not match read");

    a_read_seq: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (s_tuser == OP_READ)) |=> (state_reg == ST_RD))
        else $error("read item did not enter read state");

    a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == ST_RD))
        else $error("result raised without a read");
`endif

endmodule
